FILE: src/dht_pkg.sv
// Shared types and constants for the double hashing hash table.
// Holds the command and status words between dht_ctrl and dht_dp.
`timescale 1ns / 1ps

package dht_pkg;

   localparam int KEY_W  = 32;
   localparam int SLOT_W = 10;
   localparam int RSP_W  = 16;  // hit, stored, full_res, slot, zero padding

   // controller to datapath
   typedef struct packed {
      logic load;         // take a new request word
      logic quo_load;     // register both quotients from the reciprocal products
      logic rem_load;     // register both remainders, giving home slot and step
      logic advance;      // move to the next slot of the probe sequence
      logic clear_write;  // write zero at the clearing counter
      logic write_key;    // write the key at the current slot
      logic set_hit;
      logic set_stored;
      logic set_full;
      logic out_load;     // copy the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic key_zero;
      logic op_search;
      logic clear_last;
      logic slot_empty;
      logic key_match;
      logic probe_last;
   } sts_type;

endpackage

FILE: src/double_hash_table_insert_search_top.sv
// Open-addressing hash table, double hashing, insert and search of signed keys.
// Flow: an accepted word passes the quotient and remainder states, then a read and a compare
// per probe, before rsp_tvalid rises; a key of zero skips the modulo and the probe loop.
// A new word is taken only in the idle state, once the probe loop for the last one is done;
// a stalled response holds the next result and req_tready low until the output register frees.
// Reset: synchronous; the store is swept to zero, all TABLE_SIZE slots, req_tready low.
`timescale 1ns / 1ps

module double_hash_table_insert_search_top #(
   parameter int TABLE_SIZE = 1021,
   parameter int STEP_PRIME = 1019
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic        req_tuser,   // [0] req_type: 0 insert, 1 search
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] hit, [1] stored, [2] full_res, [12:3] slot
);

   import dht_pkg::*;

   localparam int TW = $clog2(TABLE_SIZE);

   cmd_type          cmd;
   sts_type          sts;
   logic             ram_we;
   logic [TW-1:0]    ram_addr;
   logic [KEY_W-1:0] ram_wdata;
   logic [KEY_W-1:0] ram_rdata;

   dht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   dht_dp #(
      .TABLE_SIZE (TABLE_SIZE),
      .STEP_PRIME (STEP_PRIME)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp_tdata (rsp_tdata)
   );

   dht_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

FILE: src/dht_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1021
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/dht_dp.sv
// Datapath: request registers, reciprocal-multiply modulo unit for home slot and step,
// probe address arithmetic, clearing counter and the output register.
// Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_dp #(
   parameter int TABLE_SIZE = 1021,
   parameter int STEP_PRIME = 1019
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dht_pkg::cmd_type                cmd,
   output dht_pkg::sts_type                sts,
   input  logic [dht_pkg::KEY_W-1:0]       req_tdata,
   input  logic                            req_tuser,
   output logic                            ram_we,
   output logic [$clog2(TABLE_SIZE)-1:0]   ram_addr,
   output logic [dht_pkg::KEY_W-1:0]       ram_wdata,
   input  logic [dht_pkg::KEY_W-1:0]       ram_rdata,
   output logic [dht_pkg::RSP_W-1:0]       rsp_tdata
);

   import dht_pkg::*;

   localparam int TW     = $clog2(TABLE_SIZE);
   localparam int PW     = $clog2(STEP_PRIME);
   localparam int PROD_W = 2 * KEY_W + 1;

   // ceil(2^(KEY_W+n) / d) with n = clog2(d): exact quotient for every KEY_W-bit dividend
   localparam logic [KEY_W:0] RECIP_T =
      (KEY_W+1)'(((64'd1 << (KEY_W + TW)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
   localparam logic [KEY_W:0] RECIP_P =
      (KEY_W+1)'(((64'd1 << (KEY_W + PW)) + 64'(STEP_PRIME) - 64'd1) / 64'(STEP_PRIME));

   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     mag_ff, mag_in;
   logic [KEY_W-1:0]     quo_t_ff, quo_t_in;
   logic [KEY_W-1:0]     quo_p_ff, quo_p_in;
   logic [TW-1:0]        cur_ff, cur_in;      // remainder by TABLE_SIZE, then probe slot
   logic [PW-1:0]        rem_p_ff, rem_p_in;  // remainder by STEP_PRIME
   logic [TW-1:0]        probe_ff, probe_in;
   logic [TW-1:0]        clr_ff, clr_in;
   logic                 hit_ff, hit_in;
   logic                 stored_ff, stored_in;
   logic                 full_ff, full_in;
   logic [TW-1:0]        slot_ff, slot_in;
   logic [RSP_W-1:0]     out_ff, out_in;

   logic [PROD_W-1:0]    prod_t, prod_p;
   logic [KEY_W-1:0]     rem_t, rem_p;
   logic [TW:0]          sum, sum_sub;
   logic [TW-1:0]        step;
   logic [KEY_W-1:0]     key_mag;

   // magnitude; the most negative key maps to 2^31 as unsigned
   assign key_mag = req_tdata[KEY_W-1] ? (~req_tdata + KEY_W'(1)) : req_tdata;

   assign prod_t = {{(KEY_W+1){1'b0}}, mag_ff} * {{KEY_W{1'b0}}, RECIP_T};
   assign prod_p = {{(KEY_W+1){1'b0}}, mag_ff} * {{KEY_W{1'b0}}, RECIP_P};

   // remainder is the magnitude less quotient times divisor, always below the divisor
   assign rem_t = mag_ff - quo_t_ff * KEY_W'(TABLE_SIZE);
   assign rem_p = mag_ff - quo_p_ff * KEY_W'(STEP_PRIME);

   // step is 1..STEP_PRIME, below TABLE_SIZE
   assign step    = TW'(STEP_PRIME) - TW'(rem_p_ff);
   assign sum     = {1'b0, cur_ff} + {1'b0, step};
   assign sum_sub = sum - (TW+1)'(TABLE_SIZE);

   always_comb begin
      key_in     = key_ff;
      op_in      = op_ff;
      mag_in     = mag_ff;
      quo_t_in   = quo_t_ff;
      quo_p_in   = quo_p_ff;
      cur_in     = cur_ff;
      rem_p_in   = rem_p_ff;
      probe_in   = probe_ff;
      clr_in     = clr_ff;
      hit_in     = hit_ff;
      stored_in  = stored_ff;
      full_in    = full_ff;
      slot_in    = slot_ff;
      out_in     = out_ff;

      if (cmd.load) begin
         key_in     = req_tdata;
         op_in      = req_tuser;
         mag_in     = key_mag;
         cur_in     = '0;
         rem_p_in   = '0;
         probe_in   = '0;
         hit_in     = 1'b0;
         stored_in  = 1'b0;
         full_in    = 1'b0;
         slot_in    = '0;
      end
      if (cmd.quo_load) begin
         quo_t_in = KEY_W'(prod_t >> (KEY_W + TW));
         quo_p_in = KEY_W'(prod_p >> (KEY_W + PW));
      end
      if (cmd.rem_load) begin
         cur_in   = TW'(rem_t);
         rem_p_in = PW'(rem_p);
      end
      if (cmd.advance) begin
         cur_in   = (sum >= (TW+1)'(TABLE_SIZE)) ? TW'(sum_sub) : TW'(sum);
         probe_in = probe_ff + TW'(1);
      end
      if (cmd.clear_write) begin
         clr_in = clr_ff + TW'(1);
      end
      if (cmd.set_hit) begin
         hit_in  = 1'b1;
         slot_in = cur_ff;
      end
      if (cmd.set_stored) begin
         stored_in = 1'b1;
         slot_in   = cur_ff;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.out_load) begin
         out_in = {3'b000, SLOT_W'(slot_ff), full_ff, stored_ff, hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         probe_ff   <= '0;
      end else begin
         clr_ff     <= clr_in;
         probe_ff   <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      op_ff     <= op_in;
      mag_ff    <= mag_in;
      quo_t_ff  <= quo_t_in;
      quo_p_ff  <= quo_p_in;
      cur_ff    <= cur_in;
      rem_p_ff  <= rem_p_in;
      hit_ff    <= hit_in;
      stored_ff <= stored_in;
      full_ff   <= full_in;
      slot_ff   <= slot_in;
      out_ff    <= out_in;
   end

   assign ram_we    = cmd.clear_write | cmd.write_key;
   assign ram_addr  = cmd.clear_write ? clr_ff : cur_ff;
   assign ram_wdata = cmd.clear_write ? '0 : key_ff;

   assign sts.key_zero   = (key_ff == '0);
   assign sts.op_search  = op_ff;
   assign sts.clear_last = (clr_ff == TW'(TABLE_SIZE-1));
   assign sts.slot_empty = (ram_rdata == '0);
   assign sts.key_match  = (ram_rdata == key_ff);
   assign sts.probe_last = (probe_ff == TW'(TABLE_SIZE-1));

   assign rsp_tdata = out_ff;

endmodule

FILE: src/dht_ctrl.sv
// Controller: clearing pass, modulo sequencing, probe loop and result handoff.
// Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_ctrl (
   input  logic             clock,
   input  logic             reset,
   output dht_pkg::cmd_type cmd,
   input  dht_pkg::sts_type sts,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready
);

   import dht_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_QUO   = 7'b0000100,
      ST_REM   = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_CHECK = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_QUO;
            end
         end
         ST_QUO: begin
            if (sts.key_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.quo_load = 1'b1;
               state_in     = ST_REM;
            end
         end
         ST_REM: begin
            cmd.rem_load = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!sts.op_search) begin
               if (sts.slot_empty) begin
                  cmd.write_key  = 1'b1;
                  cmd.set_stored = 1'b1;
                  state_in       = ST_DONE;
               end else if (sts.probe_last) begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end else begin
               if (sts.key_match) begin
                  cmd.set_hit = 1'b1;
                  state_in    = ST_DONE;
               end else if (sts.slot_empty || sts.probe_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
